>>> rtl/pftbl_pkg.sv
`timescale 1ns / 1ps
package pftbl_pkg;

  // Field widths fixed by the command and result words
  localparam int unsigned PEER_IN_W = 6;
  localparam int unsigned CLS_W     = 3;
  localparam int unsigned TOK_W     = 16;
  localparam int unsigned MS_W32    = 32;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned LIM_W     = 32;
  localparam int unsigned PROD_W    = MS_W32 + TOK_W;

  // Limits registers: max tokens in 15:0, refill per second in 31:16
  localparam int unsigned NUM_LIMITS = 8;
  localparam int unsigned LIM_IDX_W  = 3;
  localparam logic [LIM_W-1:0] LIMITS_RESET [NUM_LIMITS] = '{
    32'd3277300, 32'd1310920, 32'd655460, 32'd327730,
    32'd1310920, 32'd327730,  32'd65541,  32'd655460
  };

  // Defaults for the top-level parameters
  localparam int unsigned PEER_SLOTS_DEF    = 64;
  localparam int unsigned CLASSES_DEF       = 8;
  localparam int unsigned MS_PER_SECOND_DEF = 1000;

  typedef enum logic [1:0] {
    OP_CONSUME     = 2'd0,
    OP_CHECK       = 2'd1,
    OP_RESET_PEER  = 2'd2,
    OP_REMOVE_PEER = 2'd3
  } op_e;

  typedef struct packed {
    op_e                  operation;
    logic [PEER_IN_W-1:0] peer_slot;
    logic [CLS_W-1:0]     msg_class;
    logic [TOK_W-1:0]     cost;
    logic [MS_W32-1:0]    now_ms;
  } pftbl_in_t;

  typedef struct packed {
    logic             allowed;
    logic [TOK_W-1:0] tokens_left;
    logic [CNT_W-1:0] message_count;
    logic [CNT_W-1:0] blocked_count;
  } pftbl_out_t;

  // Bucket level: token count and refill stamp
  typedef struct packed {
    logic [TOK_W-1:0]  tokens;
    logic [MS_W32-1:0] stamp;
  } pftbl_lvl_t;

  // Bucket counters
  typedef struct packed {
    logic [CNT_W-1:0] seen;
    logic [CNT_W-1:0] refused;
  } pftbl_cnt_t;

endpackage

>>> rtl/pftbl_ram.sv
`timescale 1ns / 1ps
module pftbl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/per_flow_token_bucket_limiter.sv
`timescale 1ns / 1ps
// Token bucket limiter, one bucket per (peer slot, message class). A command word is taken
// when start is high and busy is low; its single result word is shown on res_o with done_o
// high for exactly one cycle, and must be taken then: there is no back-pressure. Check and
// remove-peer finish in the read state, reset-peer steps through all CLASSES classes (one
// level-memory write per existing bucket), and consume passes through the read, multiply,
// divide, refill and spend states. One shared multiplier (up to 32 by 16 bits) forms
// elapsed_ms * rate in one pass, then is reused once per 16-bit digit of a fixed
// reciprocal of MS_PER_SECOND (ND digits, 2 at 1000) to get the whole-token quotient. A
// product worth 2^16 tokens or more simply fills the bucket. The next command may be
// started in the cycle its predecessor's result is shown. After reset the block is busy
// while it clears the valid-bit memory one peer row a cycle; limits writes are taken at
// any time, including then. Token counts are exact integers, the refill stamp moves only
// when the refill is worth at least one token, and the message and blocked counters
// saturate at all ones.
module per_flow_token_bucket_limiter
  import pftbl_pkg::*;
#(
  parameter int unsigned PEER_SLOTS    = PEER_SLOTS_DEF,
  parameter int unsigned CLASSES       = CLASSES_DEF,
  parameter int unsigned MS_PER_SECOND = MS_PER_SECOND_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  pftbl_in_t            cmd_i,
  output logic                 done_o,
  output pftbl_out_t           res_o,
  input  logic                 cfg_we_i,
  input  logic [LIM_IDX_W-1:0] cfg_idx_i,
  input  logic [LIM_W-1:0]     cfg_data_i
);

  localparam int unsigned PW        = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam int unsigned BKT_DEPTH = PEER_SLOTS * NUM_LIMITS;
  localparam int unsigned BAW       = $clog2(BKT_DEPTH);
  localparam int unsigned LVL_W     = $bits(pftbl_lvl_t);
  localparam int unsigned CNTS_W    = $bits(pftbl_cnt_t);

  // Reciprocal division: a product below 2^16 * MS_PER_SECOND fits in QN bits, and
  // (n * RECIP) >> (QN + DL) is then exactly n / MS_PER_SECOND
  localparam int unsigned DL     = $clog2(MS_PER_SECOND);
  localparam int unsigned QN     = TOK_W + DL;
  localparam int unsigned RW     = QN + 1;
  localparam int unsigned ND     = (RW + TOK_W - 1) / TOK_W;
  localparam int unsigned RPW    = ND * TOK_W;
  localparam int unsigned ACC_W  = QN + RPW;
  localparam int unsigned MA_W   = (QN > MS_W32) ? QN : MS_W32;
  localparam int unsigned MP_W   = MA_W + TOK_W;
  localparam int unsigned DCNT_W = (ND > 1) ? $clog2(ND) : 1;
  localparam logic [RPW-1:0] RECIP =
    RPW'(((64'd1 << (QN + DL)) / 64'(MS_PER_SECOND)) + 64'd1);
  localparam logic [PROD_W-1:0] FULL_PROD = PROD_W'(MS_PER_SECOND) << TOK_W;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_REFILL = 3'd5;
  localparam logic [2:0] S_SPEND  = 3'd6;
  localparam logic [2:0] S_RST    = 3'd7;

  // Reduce the peer slot modulo PEER_SLOTS by binary long subtraction
  function automatic logic [PW-1:0] peer_reduce(input logic [PEER_IN_W-1:0] slot);
    logic [PEER_IN_W-1:0] r;
    r = slot;
    for (int i = PEER_IN_W - 1; i >= 0; i--) begin
      if (int'(r) >= (int'(PEER_SLOTS) << i)) begin
        r = r - PEER_IN_W'(int'(PEER_SLOTS) << i);
      end
    end
    return PW'(r);
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

  // Control state
  logic [2:0]           state_q, state_d;
  logic [PW-1:0]        clr_q, clr_d;
  logic [LIM_IDX_W-1:0] k_q, k_d;
  logic [DCNT_W-1:0]    dcnt_q, dcnt_d;
  logic                 done_q, done_d;
  logic [LIM_W-1:0]     lim_q [NUM_LIMITS];

  // Working payload
  op_e                  op_q, op_d;
  logic [PW-1:0]        peer_q, peer_d;
  logic [LIM_IDX_W-1:0] cls_q, cls_d;
  logic [TOK_W-1:0]     cost_q, cost_d;
  logic [MS_W32-1:0]    now_q, now_d;
  logic [NUM_LIMITS-1:0] vrow_q, vrow_d;
  pftbl_lvl_t           lvl_q, lvl_d;
  pftbl_cnt_t           cnt_q, cnt_d;
  logic [MS_W32-1:0]    elapsed_q, elapsed_d;
  logic [PROD_W-1:0]    dq_q, dq_d;
  logic [ACC_W-1:0]     acc_q, acc_d;
  logic [RPW-1:0]       rec_q, rec_d;
  pftbl_out_t           res_q, res_d;

  // Memory ports
  logic                  v_we;
  logic [PW-1:0]         v_waddr;
  logic [NUM_LIMITS-1:0] v_wdata, v_rdata;
  logic                  l_we, c_we;
  logic [BAW-1:0]        b_waddr, b_raddr;
  pftbl_lvl_t            l_wdata, l_rdata;
  pftbl_cnt_t            c_wdata, c_rdata;

  // Decoded inputs and helpers
  logic [PW-1:0]        peer_in;
  logic [LIM_IDX_W-1:0] cls_in;
  logic                 hit;
  logic [TOK_W-1:0]     max_cls, rate_cls, max_k;
  logic [MA_W-1:0]      mul_a;
  logic [TOK_W-1:0]     mul_b;
  logic [MP_W-1:0]      mul_p;
  logic                 fill_all;
  logic [TOK_W-1:0]     quo;
  logic [TOK_W:0]       sum;
  logic                 fits;
  logic [CNT_W-1:0]     seen_n, refused_n;
  logic [TOK_W-1:0]     tokens_n;

  assign peer_in  = peer_reduce(cmd_i.peer_slot);
  assign cls_in   = ({1'b0, cmd_i.msg_class} >= (LIM_IDX_W + 1)'(CLASSES))
                    ? LIM_IDX_W'(CLASSES - 1) : cmd_i.msg_class;
  assign max_cls  = lim_q[cls_q][TOK_W-1:0];
  assign rate_cls = lim_q[cls_q][LIM_W-1:TOK_W];
  assign max_k    = lim_q[k_q][TOK_W-1:0];
  assign hit      = v_rdata[cls_q];

  assign b_raddr = BAW'({peer_in, cls_in});
  assign b_waddr = (state_q == S_RST) ? BAW'({peer_q, k_q}) : BAW'({peer_q, cls_q});
  assign v_waddr = (state_q == S_CLEAR) ? clr_q : peer_q;

  // Shared multiplier: elapsed * rate first, then product * reciprocal digit
  assign mul_a = (state_q == S_DIV) ? MA_W'(dq_q[QN-1:0]) : MA_W'(elapsed_q);
  assign mul_b = (state_q == S_DIV) ? rec_q[RPW-1 -: TOK_W] : rate_cls;
  assign mul_p = MP_W'(mul_a) * MP_W'(mul_b);

  // Refill: add the quotient, capped at the class maximum
  assign fill_all = (dq_q >= FULL_PROD);
  assign quo      = acc_q[QN+DL +: TOK_W];
  assign sum      = {1'b0, lvl_q.tokens} + {1'b0, quo};
  assign fits     = !fill_all && (sum < {1'b0, max_cls});

  // Spend: count the message, take the cost or count a refusal
  assign seen_n    = sat_inc(cnt_q.seen);
  assign tokens_n  = (lvl_q.tokens >= cost_q) ? lvl_q.tokens - cost_q : lvl_q.tokens;
  assign refused_n = (lvl_q.tokens >= cost_q) ? cnt_q.refused : sat_inc(cnt_q.refused);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    k_d       = k_q;
    dcnt_d    = dcnt_q;
    done_d    = 1'b0;
    op_d      = op_q;
    peer_d    = peer_q;
    cls_d     = cls_q;
    cost_d    = cost_q;
    now_d     = now_q;
    vrow_d    = vrow_q;
    lvl_d     = lvl_q;
    cnt_d     = cnt_q;
    elapsed_d = elapsed_q;
    dq_d      = dq_q;
    acc_d     = acc_q;
    rec_d     = rec_q;
    res_d     = res_q;
    v_we      = 1'b0;
    v_wdata   = vrow_q;
    l_we      = 1'b0;
    l_wdata   = lvl_q;
    c_we      = 1'b0;
    c_wdata   = cnt_q;

    unique case (state_q)
      S_CLEAR: begin
        // Clear one peer row of valid bits a cycle
        v_we    = 1'b1;
        v_wdata = '0;
        if (clr_q == PW'(PEER_SLOTS - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + PW'(1);
        end
      end

      S_IDLE: begin
        if (start) begin
          op_d    = cmd_i.operation;
          peer_d  = peer_in;
          cls_d   = cls_in;
          cost_d  = cmd_i.cost;
          now_d   = cmd_i.now_ms;
          state_d = S_READ;
        end
      end

      S_READ: begin
        unique case (op_q)
          OP_CONSUME: begin
            vrow_d         = v_rdata;
            vrow_d[cls_q]  = 1'b1;
            if (hit) begin
              lvl_d     = l_rdata;
              cnt_d     = c_rdata;
              elapsed_d = now_q - l_rdata.stamp;
            end else begin
              // Create the bucket full, with zero counts
              lvl_d.tokens = max_cls;
              lvl_d.stamp  = now_q;
              cnt_d        = '0;
              elapsed_d    = '0;
            end
            state_d = S_MUL;
          end
          OP_CHECK: begin
            res_d.allowed       = !(hit && (l_rdata.tokens < cost_q));
            res_d.tokens_left   = hit ? l_rdata.tokens : '0;
            res_d.message_count = hit ? c_rdata.seen : '0;
            res_d.blocked_count = hit ? c_rdata.refused : '0;
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
          OP_RESET_PEER: begin
            vrow_d  = v_rdata;
            cnt_d   = c_rdata;
            k_d     = '0;
            state_d = S_RST;
          end
          OP_REMOVE_PEER: begin
            v_we    = 1'b1;
            v_wdata = '0;
            res_d   = '0;
            res_d.allowed = 1'b1;
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        endcase
      end

      S_MUL: begin
        dq_d    = PROD_W'(mul_p);
        acc_d   = '0;
        rec_d   = RECIP;
        dcnt_d  = '0;
        state_d = S_DIV;
      end

      S_DIV: begin
        // Multiply by the reciprocal, top 16-bit digit first
        acc_d = {acc_q[ACC_W-TOK_W-1:0], TOK_W'(0)} + ACC_W'(mul_p);
        rec_d = {rec_q[RPW-TOK_W-1:0], TOK_W'(0)};
        if (dcnt_q == DCNT_W'(ND - 1)) begin
          state_d = S_REFILL;
        end else begin
          dcnt_d = dcnt_q + DCNT_W'(1);
        end
      end

      S_REFILL: begin
        // Move the stamp only when the refill is worth at least one token
        if (fill_all || (quo != '0)) begin
          lvl_d.tokens = fits ? sum[TOK_W-1:0] : max_cls;
          lvl_d.stamp  = now_q;
        end
        state_d = S_SPEND;
      end

      S_SPEND: begin
        l_we            = 1'b1;
        l_wdata.tokens  = tokens_n;
        l_wdata.stamp   = lvl_q.stamp;
        c_we            = 1'b1;
        c_wdata.seen    = seen_n;
        c_wdata.refused = refused_n;
        v_we            = 1'b1;
        v_wdata         = vrow_q;
        res_d.allowed       = (lvl_q.tokens >= cost_q);
        res_d.tokens_left   = tokens_n;
        res_d.message_count = seen_n;
        res_d.blocked_count = refused_n;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      S_RST: begin
        // Refill and restamp each existing bucket of the peer, one class a cycle
        if (vrow_q[k_q]) begin
          l_we           = 1'b1;
          l_wdata.tokens = max_k;
          l_wdata.stamp  = now_q;
        end
        if (k_q == LIM_IDX_W'(CLASSES - 1)) begin
          res_d.allowed       = 1'b1;
          res_d.tokens_left   = vrow_q[cls_q] ? max_cls : '0;
          res_d.message_count = vrow_q[cls_q] ? cnt_q.seen : '0;
          res_d.blocked_count = vrow_q[cls_q] ? cnt_q.refused : '0;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          k_d = k_q + LIM_IDX_W'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      k_q     <= '0;
      dcnt_q  <= '0;
      done_q  <= 1'b0;
      for (int i = 0; i < NUM_LIMITS; i++) begin
        lim_q[i] <= LIMITS_RESET[i];
      end
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      k_q     <= k_d;
      dcnt_q  <= dcnt_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        lim_q[cfg_idx_i] <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    peer_q    <= peer_d;
    cls_q     <= cls_d;
    cost_q    <= cost_d;
    now_q     <= now_d;
    vrow_q    <= vrow_d;
    lvl_q     <= lvl_d;
    cnt_q     <= cnt_d;
    elapsed_q <= elapsed_d;
    dq_q      <= dq_d;
    acc_q     <= acc_d;
    rec_q     <= rec_d;
    res_q     <= res_d;
  end

  // Valid bits, one row of classes per peer
  pftbl_ram #(
    .WIDTH (NUM_LIMITS),
    .DEPTH (PEER_SLOTS)
  ) u_valid_ram (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (v_waddr),
    .wdata_i (v_wdata),
    .raddr_i (peer_in),
    .rdata_o (v_rdata)
  );

  // Token count and refill stamp per bucket
  pftbl_ram #(
    .WIDTH (LVL_W),
    .DEPTH (BKT_DEPTH)
  ) u_level_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (b_waddr),
    .wdata_i (l_wdata),
    .raddr_i (b_raddr),
    .rdata_o (l_rdata)
  );

  // Message and blocked counters per bucket
  pftbl_ram #(
    .WIDTH (CNTS_W),
    .DEPTH (BKT_DEPTH)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (b_waddr),
    .wdata_i (c_wdata),
    .raddr_i (b_raddr),
    .rdata_o (c_rdata)
  );

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> rtl/pftbl_chk.sv
`timescale 1ns / 1ps
module pftbl_chk
  import pftbl_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input pftbl_out_t res_o
);

  // An accepted word keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a word");

  // A result is shown only as the block returns to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // Every word passes through the read state after it is accepted, so results never come back to back
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("results in consecutive cycles");

  // A refusal only comes from an existing bucket that has counted messages
  a_refusal_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.allowed) |-> (res_o.message_count != '0))
    else $error("refusal from a bucket with no messages");

  // Blocked messages never outnumber seen messages
  a_blocked_le_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.blocked_count <= res_o.message_count))
    else $error("blocked count above message count");

endmodule

bind per_flow_token_bucket_limiter pftbl_chk u_pftbl_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .res_o  (res_o)
);

>>> tb/sv/pftbl_bucket_checker.sv
`timescale 1ns / 1ps
module pftbl_bucket_checker
  import pftbl_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  pftbl_in_t            cmd_i,
  input  logic                 done_i,
  input  pftbl_out_t           res_i,
  input  logic                 cfg_we_i,
  input  logic [LIM_IDX_W-1:0] cfg_idx_i,
  input  logic [LIM_W-1:0]     cfg_data_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);

  localparam int unsigned NBKT = PEER_SLOTS_DEF * CLASSES_DEF;

  logic [LIM_W-1:0]  limits  [NUM_LIMITS];
  bit                live    [NBKT];
  bit [TOK_W-1:0]    tokens  [NBKT];
  bit [MS_W32-1:0]   stamp   [NBKT];
  bit [CNT_W-1:0]    seen    [NBKT];
  bit [CNT_W-1:0]    refused [NBKT];

  pftbl_out_t  predicted_res_q [$];
  pftbl_out_t  want;
  int unsigned errors = 0;

  assign fail_count_o = errors;

  function automatic bit [CNT_W-1:0] sat_inc(bit [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Apply one command word to the bucket state and return its result word.
  function automatic pftbl_out_t bucket_step(pftbl_in_t w);
    int unsigned     cls;
    int unsigned     base;
    int unsigned     b;
    int unsigned     k;
    bit [TOK_W-1:0]  cap;
    bit [TOK_W-1:0]  rate;
    bit [MS_W32-1:0] elapsed;
    bit [63:0]       gained;
    bit [63:0]       level;
    pftbl_out_t      r;
    cls = w.msg_class;
    if (cls >= CLASSES_DEF) cls = CLASSES_DEF - 1;
    base = (w.peer_slot % PEER_SLOTS_DEF) * CLASSES_DEF;
    b = base + cls;
    r = '0;
    r.allowed = 1'b1;
    case (w.operation)
      OP_CONSUME: begin
        cap  = limits[cls][15:0];
        rate = limits[cls][31:16];
        if (!live[b]) begin
          live[b]    = 1'b1;
          tokens[b]  = cap;
          stamp[b]   = w.now_ms;
          seen[b]    = '0;
          refused[b] = '0;
        end
        // elapsed wraps modulo 2^32; restamp only when a token is gained
        elapsed = w.now_ms - stamp[b];
        gained  = ({32'd0, elapsed} * {48'd0, rate}) / MS_PER_SECOND_DEF;
        if (gained != 0) begin
          level     = {48'd0, tokens[b]} + gained;
          tokens[b] = (level < {48'd0, cap}) ? level[TOK_W-1:0] : cap;
          stamp[b]  = w.now_ms;
        end
        seen[b] = sat_inc(seen[b]);
        if (tokens[b] >= w.cost) begin
          tokens[b] = tokens[b] - w.cost;
        end else begin
          refused[b] = sat_inc(refused[b]);
          r.allowed  = 1'b0;
        end
      end
      OP_CHECK: begin
        if (live[b] && tokens[b] < w.cost) r.allowed = 1'b0;
      end
      OP_RESET_PEER: begin
        for (k = 0; k < CLASSES_DEF; k++) begin
          if (live[base + k]) begin
            tokens[base + k] = limits[k][15:0];
            stamp[base + k]  = w.now_ms;
          end
        end
      end
      default: begin
        for (k = 0; k < CLASSES_DEF; k++) live[base + k] = 1'b0;
      end
    endcase
    if (live[b]) begin
      r.tokens_left   = tokens[b];
      r.message_count = seen[b];
      r.blocked_count = refused[b];
    end
    return r;
  endfunction

  // Compare the word leaving the block before queueing the one entering it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LIMITS; i++) limits[i] = LIMITS_RESET[i];
      for (int i = 0; i < NBKT; i++) live[i] = 1'b0;
      predicted_res_q.delete();
      pending_o <= 0;
    end else begin
      if (done_i) begin
        if (predicted_res_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word allowed=%0b tokens=%0d msgs=%0d blocked=%0d",
                   $time, res_i.allowed, res_i.tokens_left, res_i.message_count,
                   res_i.blocked_count);
        end else begin
          want = predicted_res_q.pop_front();
          if (res_i !== want) begin
            errors++;
            $display({"%0t: mismatch expected allowed=%0b tokens=%0d msgs=%0d blocked=%0d",
                      " got allowed=%0b tokens=%0d msgs=%0d blocked=%0d"},
                     $time, want.allowed, want.tokens_left, want.message_count,
                     want.blocked_count, res_i.allowed, res_i.tokens_left,
                     res_i.message_count, res_i.blocked_count);
          end
        end
      end
      if (start_i && !busy_i) predicted_res_q.push_back(bucket_step(cmd_i));
      if (cfg_we_i) limits[cfg_idx_i] = cfg_data_i;
      pending_o <= predicted_res_q.size();
    end
  end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import pftbl_pkg::*;

  // Generous cap on the run length, covering every command and the idle gaps between sends.
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned TAIL_CYCLES     = 64;
  localparam int unsigned WORDS_PER_PHASE = 300;

  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 start      = 1'b0;
  logic                 busy;
  pftbl_in_t            cmd_i      = '0;
  logic                 done_o;
  pftbl_out_t           res_o;
  logic                 cfg_we_i   = 1'b0;
  logic [LIM_IDX_W-1:0] cfg_idx_i  = '0;
  logic [LIM_W-1:0]     cfg_data_i = '0;

  int unsigned      fail_count;
  int unsigned      pending;
  int unsigned      cycles     = 0;
  int unsigned      burst_left = 0;
  bit [MS_W32-1:0]  wall_ms    = '0;
  logic [LIM_W-1:0] limits_next [NUM_LIMITS];

  per_flow_token_bucket_limiter u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .done_o     (done_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  pftbl_bucket_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .cmd_i        (cmd_i),
    .done_i       (done_o),
    .res_i        (res_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("per_flow_token_bucket_limiter verification failed");
      $finish;
    end
  end

  function automatic pftbl_in_t make_word(op_e op, logic [PEER_IN_W-1:0] peer,
                                          logic [CLS_W-1:0] cls, logic [TOK_W-1:0] cost,
                                          logic [MS_W32-1:0] ms);
    pftbl_in_t w;
    w.operation = op;
    w.peer_slot = peer;
    w.msg_class = cls;
    w.cost      = cost;
    w.now_ms    = ms;
    return w;
  endfunction

  // Build a random command word; advance the running millisecond time as a side effect.
  function automatic pftbl_in_t random_word();
    pftbl_in_t   w;
    int unsigned pick;
    // Mostly small steps so buckets drain and refill; sometimes long jumps and wraps.
    pick = $urandom_range(99, 0);
    if (pick < 55)      wall_ms = wall_ms + $urandom_range(40, 0);
    else if (pick < 85) wall_ms = wall_ms + $urandom_range(3000, 0);
    else if (pick < 95) wall_ms = wall_ms + $urandom;
    else                wall_ms = 32'hFFFF_FFFF - $urandom_range(200, 0);
    w.now_ms = wall_ms;
    pick = $urandom_range(99, 0);
    if (pick < 58)      w.operation = OP_CONSUME;
    else if (pick < 82) w.operation = OP_CHECK;
    else if (pick < 93) w.operation = OP_RESET_PEER;
    else                w.operation = OP_REMOVE_PEER;
    // Keep most traffic on a few hot peers so buckets live long enough to matter.
    if ($urandom_range(99, 0) < 70) w.peer_slot = PEER_IN_W'($urandom_range(3, 0));
    else                            w.peer_slot = PEER_IN_W'($urandom_range(63, 0));
    w.msg_class = CLS_W'($urandom_range(7, 0));
    pick = $urandom_range(99, 0);
    if (pick < 45)      w.cost = TOK_W'($urandom_range(12, 0));
    else if (pick < 70) w.cost = TOK_W'($urandom_range(600, 0));
    else if (pick < 80) w.cost = '0;
    else if (pick < 92) w.cost = TOK_W'($urandom_range(65535, 0));
    else                w.cost = 16'hFFFF - TOK_W'($urandom_range(3, 0));
    return w;
  endfunction

  // Present one word and hold it until accepted; idle between random bursts.
  task automatic send_word(input pftbl_in_t w);
    start <= 1'b1;
    cmd_i <= w;
    do @(posedge clk_i); while (busy);
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clk_i);
      // Now and then a long burst with no idle cycles at all.
      if ($urandom_range(9, 0) == 0) burst_left = $urandom_range(60, 30);
      else                           burst_left = $urandom_range(8, 1);
    end
  endtask

  // Drop start and wait until every predicted word has come back and the block is idle.
  task automatic settle();
    if (start) start <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy);
  endtask

  // Write all limits registers from limits_next, one per cycle.
  task automatic load_limits();
    for (int i = 0; i < NUM_LIMITS; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= i[LIM_IDX_W-1:0];
      cfg_data_i <= limits_next[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_traffic(input int unsigned n);
    repeat (n) send_word(random_word());
    settle();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Wait out the valid-bit clearing pass.
    settle();

    // Default limits: class 0 holds 500 at 50/s, class 7 100 at 10/s, class 6 5 at 1/s.
    send_word(make_word(OP_CHECK,   6'd0, 3'd0, 16'd1,     32'd1000));  // absent bucket
    send_word(make_word(OP_CONSUME, 6'd0, 3'd0, 16'd0,     32'd1000));  // create full
    send_word(make_word(OP_CONSUME, 6'd0, 3'd0, 16'hFFFF,  32'd1000));  // refuse max cost
    send_word(make_word(OP_CONSUME, 6'd0, 3'd0, 16'd500,   32'd1000));  // drain exactly
    send_word(make_word(OP_CONSUME, 6'd0, 3'd0, 16'd1,     32'd1019));  // no token: keep stamp
    send_word(make_word(OP_CONSUME, 6'd0, 3'd0, 16'd1,     32'd1021));  // first token now
    send_word(make_word(OP_CHECK,   6'd0, 3'd0, 16'd0,     32'd1021));
    send_word(make_word(OP_CHECK,   6'd0, 3'd0, 16'd1,     32'd5000));  // check never refills
    send_word(make_word(OP_CONSUME, 6'd1, 3'd7, 16'd100,   32'hFFFF_FFF0));
    send_word(make_word(OP_CONSUME, 6'd1, 3'd7, 16'd2,     32'h0000_0100));  // across wrap
    send_word(make_word(OP_CONSUME, 6'd2, 3'd0, 16'd0,     32'd2000));
    send_word(make_word(OP_CONSUME, 6'd2, 3'd1, 16'd200,   32'd2000));
    send_word(make_word(OP_CONSUME, 6'd63, 3'd6, 16'd5,    32'd3000));
    send_word(make_word(OP_CONSUME, 6'd63, 3'd6, 16'd1,    32'd3999));
    send_word(make_word(OP_CONSUME, 6'd63, 3'd5, 16'd0,    32'd3000));
    send_word(make_word(OP_RESET_PEER,  6'd63, 3'd6, 16'd0, 32'd5000));
    send_word(make_word(OP_RESET_PEER,  6'd5,  3'd2, 16'd0, 32'd5000));  // peer with no buckets
    send_word(make_word(OP_REMOVE_PEER, 6'd1,  3'd7, 16'd0, 32'd6000));
    send_word(make_word(OP_CHECK,       6'd1,  3'd7, 16'hFFFF, 32'd6000));
    send_word(make_word(OP_REMOVE_PEER, 6'd9,  3'd4, 16'd0, 32'd6000));  // peer with no buckets
    send_word(make_word(OP_CONSUME,     6'd1,  3'd7, 16'd0, 32'd6000));  // recreate after remove
    settle();

    // Lower class 0 to 10 tokens at 1000/s, stop class 1 refill, pin class 3 at zero.
    limits_next[0] = {16'd1000, 16'd10};
    limits_next[1] = {16'd0, 16'd200};
    limits_next[2] = {16'hFFFF, 16'hFFFF};
    limits_next[3] = '0;
    for (int i = 4; i < NUM_LIMITS; i++) limits_next[i] = $urandom;
    load_limits();
    send_word(make_word(OP_CONSUME, 6'd2, 3'd0, 16'd0, 32'd2000));    // keep 500 above max
    send_word(make_word(OP_CONSUME, 6'd2, 3'd0, 16'd0, 32'd2001));    // refill caps to 10
    send_word(make_word(OP_CONSUME, 6'd2, 3'd1, 16'd1, 32'd900000));  // zero rate stays empty
    send_word(make_word(OP_CONSUME, 6'd3, 3'd3, 16'd0, 32'd100));     // zero max, zero cost
    wall_ms = 32'd1_000_000;
    run_traffic(WORDS_PER_PHASE);

    // Back to the reset values.
    for (int i = 0; i < NUM_LIMITS; i++) limits_next[i] = LIMITS_RESET[i];
    load_limits();
    run_traffic(WORDS_PER_PHASE);

    // Everything zero: new buckets start empty and no bucket refills.
    for (int i = 0; i < NUM_LIMITS; i++) limits_next[i] = '0;
    load_limits();
    run_traffic(WORDS_PER_PHASE);

    // Everything at full scale.
    for (int i = 0; i < NUM_LIMITS; i++) limits_next[i] = '1;
    load_limits();
    run_traffic(WORDS_PER_PHASE);

    // Small buckets with moderate rates keep refusals and refills frequent.
    for (int i = 0; i < NUM_LIMITS; i++) begin
      limits_next[i] = {16'($urandom_range(2000, 0)), 16'($urandom_range(64, 1))};
    end
    load_limits();
    run_traffic(WORDS_PER_PHASE);

    // Arbitrary register contents.
    for (int i = 0; i < NUM_LIMITS; i++) limits_next[i] = $urandom;
    load_limits();
    run_traffic(WORDS_PER_PHASE);

    // Let any stray result word surface before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("per_flow_token_bucket_limiter verification clean");
    end else begin
      $display("per_flow_token_bucket_limiter verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/pftbl_pkg.sv
rtl/pftbl_ram.sv
rtl/per_flow_token_bucket_limiter.sv
rtl/pftbl_chk.sv
tb/sv/pftbl_bucket_checker.sv
tb/sv/testbench.sv
